// ===== rtl/q2e_pkg.sv =====
// q2e_pkg: widths, constants, the atan table and the queue word type
// for the quaternion to euler angles block; no dependencies
`default_nettype none
package q2e_pkg;

    localparam int QW          = 16;  // quaternion component width
    localparam int PW          = 32;  // 16x16 product width
    localparam int TW          = 34;  // doubled sum of products
    localparam int SW          = 30;  // clamped yaw sine term
    localparam int CW          = 36;  // cordic x/y datapath
    localparam int ZW          = 26;  // cordic angle, 2^-16 degree
    localparam int STEPS       = 23;  // cordic micro-rotations
    localparam int ROOT_STEPS  = 29;  // result bits of the square root
    localparam int RW          = 58;  // square root remainder width
    localparam int QDEPTH_DEF  = 4;

    localparam logic signed [TW-1:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [ZW-1:0] DEG90   = 26'sd5898240;
    localparam logic signed [ZW-1:0] DEG180  = 26'sd11796480;
    localparam logic signed [15:0]   LIM_PR  = 16'sd23040;
    localparam logic signed [15:0]   LIM_Y   = 16'sd11520;

    // round(atan(2^-i) * 180/pi * 2^16)
    localparam int ATAN_TAB [0:STEPS-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1
    };

    typedef struct packed {
        logic signed [TW-1:0] t0;
        logic signed [TW-1:0] t1;
        logic signed [TW-1:0] t3;
        logic signed [TW-1:0] t4;
        logic signed [SW-1:0] t2;
    } q2e_word_t;

endpackage
`default_nettype wire

// ===== rtl/q2e_in_if.sv =====
// q2e_in_if: input channel carrying one quaternion per word
// depends on q2e_pkg
`default_nettype none
interface q2e_in_if;
    import q2e_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/q2e_out_if.sv =====
// q2e_out_if: output channel carrying pitch, yaw and roll per word
// no dependencies
`default_nettype none
interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_deg;
    logic signed [14:0] yaw_deg;
    logic signed [15:0] roll_deg;

    modport source (output valid, pitch_deg, yaw_deg, roll_deg, input ready);
    modport sink   (input valid, pitch_deg, yaw_deg, roll_deg, output ready);
endinterface
`default_nettype wire

// ===== rtl/q2e_front.sv =====
// q2e_front: accepts quaternions, forms the five atan2/asin terms in two stages
// depends on q2e_pkg and q2e_in_if
`default_nettype none
module q2e_front (
    input  wire                 clk,
    input  wire                 rst_n,
    q2e_in_if.sink              quat_in,
    output logic                push,
    output q2e_pkg::q2e_word_t  word,
    input  wire                 full
);
    import q2e_pkg::*;

    logic adv;
    logic v1_reg, v2_reg;
    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [PW-1:0] wz_reg, xy_reg, zz_reg;
    q2e_word_t word_reg, word_next;
    logic signed [TW-1:0] t2_full;

    assign adv           = !v2_reg || !full;
    assign quat_in.ready = adv;
    assign push          = v2_reg && !full;
    assign word          = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= quat_in.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg   <= quat_in.quat_w * quat_in.quat_x;
            yz_reg   <= quat_in.quat_y * quat_in.quat_z;
            xx_reg   <= quat_in.quat_x * quat_in.quat_x;
            yy_reg   <= quat_in.quat_y * quat_in.quat_y;
            wy_reg   <= quat_in.quat_w * quat_in.quat_y;
            zx_reg   <= quat_in.quat_z * quat_in.quat_x;
            wz_reg   <= quat_in.quat_w * quat_in.quat_z;
            xy_reg   <= quat_in.quat_x * quat_in.quat_y;
            zz_reg   <= quat_in.quat_z * quat_in.quat_z;
            word_reg <= word_next;
        end
    end

    always_comb
    begin
        word_next.t0 = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        word_next.t1 = ONE_Q28 - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        word_next.t3 = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        word_next.t4 = ONE_Q28 - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        t2_full      = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
        // clamp the sine term to [-1, 1]
        if (t2_full > ONE_Q28)
            word_next.t2 = SW'(ONE_Q28);
        else if (t2_full < -ONE_Q28)
            word_next.t2 = SW'(-ONE_Q28);
        else
            word_next.t2 = SW'(t2_full);
    end
endmodule
`default_nettype wire

// ===== rtl/q2e_queue.sv =====
// q2e_queue: short word queue between front and back
// depends on q2e_pkg
`default_nettype none
module q2e_queue #(
    parameter int DEPTH = q2e_pkg::QDEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  q2e_pkg::q2e_word_t  push_word,
    output logic                full,
    input  wire                 pop,
    output q2e_pkg::q2e_word_t  head,
    output logic                empty
);
    import q2e_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    q2e_word_t mem [0:DEPTH-1];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CNTW-1:0] cnt_reg;

    assign full  = (cnt_reg == CNTW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/q2e_cordic.sv =====
// q2e_cordic: pipelined vectoring cordic giving atan2(y, x) in 2^-16 degree
// depends on q2e_pkg; one quadrant stage then one stage per micro-rotation
`default_nettype none
module q2e_cordic (
    input  wire                          clk,
    input  wire                          en,
    input  wire signed [q2e_pkg::CW-1:0] x_in,
    input  wire signed [q2e_pkg::CW-1:0] y_in,
    output logic signed [q2e_pkg::ZW-1:0] z_out
);
    import q2e_pkg::*;

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0] z_reg [0:STEPS];
    logic                 hold_reg [0:STEPS];

    logic signed [CW-1:0] x_pre, y_pre;
    logic signed [ZW-1:0] z_pre;
    logic                 hold_pre;

    always_comb
    begin
        x_pre    = x_in;
        y_pre    = y_in;
        z_pre    = '0;
        hold_pre = 1'b0;
        if (x_in == '0)
        begin
            // on the y axis: angle is fixed, no rotation
            hold_pre = 1'b1;
            if (y_in > 0)
                z_pre = DEG90;
            else if (y_in < 0)
                z_pre = -DEG90;
        end
        else if (x_in < 0)
        begin
            z_pre = (y_in >= 0) ? DEG180 : -DEG180;
            x_pre = -x_in;
            y_pre = -y_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            z_reg[0]    <= z_pre;
            hold_reg[0] <= hold_pre;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hold_reg[i+1] <= hold_reg[i];
                if (hold_reg[i])
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
                else if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'(ATAN_TAB[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'(ATAN_TAB[i]);
                end
            end
        end
    end

    assign z_out = z_reg[STEPS];
endmodule
`default_nettype wire

// ===== rtl/q2e_back.sv =====
// q2e_back: square root for the yaw cosine, three cordics, rounding and output word
// depends on q2e_pkg, q2e_out_if and q2e_cordic
`default_nettype none
module q2e_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  q2e_pkg::q2e_word_t  head,
    input  wire                 empty,
    output logic                pop,
    q2e_out_if.source           angle_out
);
    import q2e_pkg::*;

    // square stage, root stages, cordic stages, output register
    localparam int NST = 1 + ROOT_STEPS + STEPS + 1 + 1;

    logic adv;
    logic vld_reg [0:NST-1];

    logic [RW-1:0] sq_reg;
    q2e_word_t     w0_reg;
    logic [RW-1:0] v_reg [0:ROOT_STEPS-1];
    logic [RW-1:0] r_reg [0:ROOT_STEPS-1];
    q2e_word_t     wd_reg [0:ROOT_STEPS-1];
    logic [RW-1:0] rad;

    logic signed [ZW-1:0] zp, zy, zr;
    logic signed [15:0]   pitch_reg, roll_reg;
    logic signed [14:0]   yaw_reg;
    logic signed [2*SW-1:0] sq_full;

    function automatic logic signed [15:0] rnd_sat(input logic signed [ZW-1:0] z,
                                                   input logic signed [15:0] lim);
        logic signed [ZW:0] s;
        logic signed [ZW:0] r;
        s = (ZW+1)'(z) + (ZW+1)'(256);
        r = s >>> 9;
        if (r > lim)
            r = (ZW+1)'(lim);
        else if (r < -lim)
            r = -(ZW+1)'(lim);
        return 16'(r);
    endfunction

    assign adv = !vld_reg[NST-1] || angle_out.ready;
    assign pop = adv && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= !empty;
            for (int k = 1; k < NST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign sq_full = head.t2 * head.t2;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= RW'(sq_full);
            w0_reg <= head;
        end
    end

    assign rad = (RW'(1) << 56) - sq_reg;

    // one result bit per stage, test bit walks down from 4^28
    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        localparam logic [RW-1:0] BITV = RW'(1) << (2 * (ROOT_STEPS - 1 - j));
        logic [RW-1:0] v_in, r_in;
        q2e_word_t     w_in;
        if (j == 0)
        begin : g_first
            assign v_in = rad;
            assign r_in = '0;
            assign w_in = w0_reg;
        end
        else
        begin : g_rest
            assign v_in = v_reg[j-1];
            assign r_in = r_reg[j-1];
            assign w_in = wd_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                wd_reg[j] <= w_in;
                if (v_in >= r_in + BITV)
                begin
                    v_reg[j] <= v_in - (r_in + BITV);
                    r_reg[j] <= (r_in >> 1) + BITV;
                end
                else
                begin
                    v_reg[j] <= v_in;
                    r_reg[j] <= r_in >> 1;
                end
            end
        end
    end

    q2e_cordic u_pitch (
        .clk   (clk),
        .en    (adv),
        .x_in  (CW'(wd_reg[ROOT_STEPS-1].t1)),
        .y_in  (CW'(wd_reg[ROOT_STEPS-1].t0)),
        .z_out (zp)
    );

    q2e_cordic u_yaw (
        .clk   (clk),
        .en    (adv),
        .x_in  (CW'($signed({1'b0, r_reg[ROOT_STEPS-1][ROOT_STEPS-1:0]}))),
        .y_in  (CW'(wd_reg[ROOT_STEPS-1].t2)),
        .z_out (zy)
    );

    q2e_cordic u_roll (
        .clk   (clk),
        .en    (adv),
        .x_in  (CW'(wd_reg[ROOT_STEPS-1].t4)),
        .y_in  (CW'(wd_reg[ROOT_STEPS-1].t3)),
        .z_out (zr)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= rnd_sat(zp, LIM_PR);
            yaw_reg   <= 15'(rnd_sat(zy, LIM_Y));
            roll_reg  <= rnd_sat(zr, LIM_PR);
        end
    end

    assign angle_out.valid     = vld_reg[NST-1];
    assign angle_out.pitch_deg = pitch_reg;
    assign angle_out.yaw_deg   = yaw_reg;
    assign angle_out.roll_deg  = roll_reg;
endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler_angles.sv =====
// quaternion to euler angles: pitch, yaw, roll in 1/128 degree from a Q1.14 quaternion
// path: 2 front stages, the word queue, then 55 back stages (square,
// 29 root stages, 24 cordic stages, output register)
// throughput: one word per cycle unless angle_out back-pressure stalls the pipe; every
// stage is a register, the long parts are the 29-stage square root and the 23-step cordics
// reset: asynchronous active-low rst_n clears all valid bits and the queue pointers
`default_nettype none
module quaternion_to_euler_angles #(
    parameter int QUEUE_DEPTH = q2e_pkg::QDEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    q2e_in_if.sink     quat_in,
    q2e_out_if.source  angle_out
);
    import q2e_pkg::*;

    logic      push, full, pop, empty;
    q2e_word_t push_word, head;

    q2e_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .quat_in (quat_in),
        .push    (push),
        .word    (push_word),
        .full    (full)
    );

    q2e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    q2e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .angle_out (angle_out)
    );
endmodule
`default_nettype wire

// ===== verif/quaternion_to_euler_angles_test.sv =====
// quaternion_to_euler_angles_test: checks pitch, yaw and roll words against a
// predictor built here; depends on q2e_pkg, q2e_in_if, q2e_out_if and the rtl
`default_nettype none
module quaternion_to_euler_angles_test;
    import q2e_pkg::*;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [14:0] yaw;
        logic signed [15:0] roll;
    } angles_t;

    localparam longint ANGLE_LIMIT_PR = 23040;
    localparam longint ANGLE_LIMIT_Y  = 11520;
    localparam int     STALL_LIMIT    = 20000;
    localparam int     LATENCY        = 64;

    logic clk;
    logic rst_n;

    q2e_in_if  quat_in ();
    q2e_out_if angle_out ();

    quaternion_to_euler_angles i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat_in   (quat_in.sink),
        .angle_out (angle_out.source)
    );

    longint deg_tab [0:22] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1
    };

    angles_t expected_angles [$];
    int      mismatches;
    int      idle_pct;
    bit      hold_off;
    int      quiet_cycles;
    bit      timed_out;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint floor_div(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return ~((~v) >>> s);
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle in 2^-16 degree
    function automatic longint vector_angle(longint y, longint x);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        if (x == 0)
            return (y > 0) ? (64'sd90 <<< 16) : (y < 0) ? -(64'sd90 <<< 16) : 0;
        if (x < 0)
        begin
            ang = (y >= 0) ? (64'sd180 <<< 16) : -(64'sd180 <<< 16);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 23; i++)
        begin
            xs = floor_div(x, i);
            ys = floor_div(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                ang = ang + deg_tab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                ang = ang - deg_tab[i];
            end
        end
        return ang;
    endfunction

    function automatic longint to_degrees(longint ang, longint lim);
        longint r;
        r = floor_div(ang + 256, 9);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic angles_t predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                               logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, one, s0, c0, sy, cy, s2, c2;
        angles_t a;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        one = 64'sd1 <<< 28;
        s0 = 2 * (w * x + y * z);
        c0 = one - 2 * (x * x + y * y);
        sy = 2 * (w * y - z * x);
        s2 = 2 * (w * z + x * y);
        c2 = one - 2 * (y * y + z * z);
        if (sy > one)
            sy = one;
        if (sy < -one)
            sy = -one;
        cy = root_floor((64'sd1 <<< 56) - sy * sy);
        a.pitch = 16'(to_degrees(vector_angle(s0, c0), ANGLE_LIMIT_PR));
        a.yaw   = 15'(to_degrees(vector_angle(sy, cy), ANGLE_LIMIT_Y));
        a.roll  = 16'(to_degrees(vector_angle(s2, c2), ANGLE_LIMIT_PR));
        return a;
    endfunction

    // valid stays high after acceptance so that a following word goes out back to back
    task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            quat_in.valid <= 1'b0;
            @(posedge clk);
        end
        quat_in.valid  <= 1'b1;
        quat_in.quat_w <= qw;
        quat_in.quat_x <= qx;
        quat_in.quat_y <= qy;
        quat_in.quat_z <= qz;
        do
            @(posedge clk);
        while (!quat_in.ready);
        expected_angles.push_back(predict_angles(qw, qx, qy, qz));
    endtask

    task automatic wait_drained();
        quat_in.valid <= 1'b0;
        while (expected_angles.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic signed [15:0] edge_vals [0:6];
        edge_vals = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd16384, -16'sd16384, 16'sd1, -16'sd1};
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(16'sd11585, 0, 16'sd11585, 0);
        send_quat(16'sd11585, 0, -16'sd11585, 0);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_quat(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_quat(0, 16'sd16384, 16'sd16384, 0);
        send_quat(0, 0, 16'sd16384, 16'sd16384);
        send_quat(0, 16'sd100, 0, 0);
        send_quat(0, -16'sd100, 0, 0);
        for (int i = 0; i < 7; i++)
            send_quat(edge_vals[i], edge_vals[(i + 2) % 7], edge_vals[(i + 4) % 7],
                      edge_vals[(i + 5) % 7]);
    endtask

    // independent components in -9000..9000, raw 16-bit noise for about one word in four
    task automatic test_random(int count);
        logic signed [15:0] q [0:3];
        for (int n = 0; n < count; n++)
        begin
            idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 15;
            if ($urandom_range(3) == 0)
                for (int k = 0; k < 4; k++)
                    q[k] = 16'($urandom);
            else
                for (int k = 0; k < 4; k++)
                    q[k] = 16'($signed($urandom_range(18000)) - 9000);
            send_quat(q[0], q[1], q[2], q[3]);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(120);
        join
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        quat_in.valid = 1'b0;
        quat_in.quat_w = '0;
        quat_in.quat_x = '0;
        quat_in.quat_y = '0;
        quat_in.quat_z = '0;
        angle_out.ready = 1'b0;
        idle_pct = 15;
        hold_off = 1'b0;
        mismatches = 0;
        timed_out = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        wait_drained();
        test_backpressure();
        test_random(700);
        wait_drained();
        repeat (LATENCY)
            @(posedge clk);
        if (mismatches == 0 && !timed_out)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            angle_out.ready <= 1'b0;
        else
            angle_out.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n && angle_out.valid && angle_out.ready)
        begin
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pitch %0d yaw %0d roll %0d",
                             angle_out.pitch_deg, angle_out.yaw_deg, angle_out.roll_deg);
            end
            else
            begin
                e = expected_angles.pop_front();
                if (e.pitch !== angle_out.pitch_deg || e.yaw !== angle_out.yaw_deg
                    || e.roll !== angle_out.roll_deg)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 e.pitch, e.yaw, e.roll, angle_out.pitch_deg,
                                 angle_out.yaw_deg, angle_out.roll_deg);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((quat_in.valid && quat_in.ready) || (angle_out.valid && angle_out.ready)
            || (!quat_in.valid && expected_angles.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
        quiet_cycles = 0;
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/q2e_pkg.sv
rtl/q2e_in_if.sv
rtl/q2e_out_if.sv
rtl/q2e_front.sv
rtl/q2e_queue.sv
rtl/q2e_cordic.sv
rtl/q2e_back.sv
rtl/quaternion_to_euler_angles.sv
verif/quaternion_to_euler_angles_test.sv
